// ----- hdl/rlsc_pkg.sv -----
// shared types and constants for the refcounted lru slot cache
// item structs, request kinds and sequencer states; no dependencies
package rlsc_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned SC_W      = 15;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_TOUCH   = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_FETCH,
    S_UPDATE
  } state_e;

  typedef enum logic {
    MODE_FRONT,
    MODE_BACK
  } mode_e;

  typedef struct packed {
    kind_e              kind;
    logic [KEY_W-1:0]   key;
    logic [IDX_W-1:0]   slot_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   slot_out;
    logic               hit;
    logic               index_ok;
    logic [CNT_W-1:0]   use_count;
    logic [KEY_W-1:0]   key_out;
    logic               evicted_busy;
  } out_item_t;

endpackage

// ----- hdl/rlsc_slot_ram.sv -----
// slot record memory: one write port, one read port with registered data
// no package dependency
module rlsc_slot_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 55,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/refcounted_lru_slot_cache.sv -----
// top level of the refcounted lru slot cache: sequencer and slot datapath
// depends on rlsc_pkg and rlsc_slot_ram

// After reset the block runs a clearing pass over the slot memory with
// busy_o high; items are taken once busy_o drops. All slot state (key,
// valid, count, recency rank) lives in one memory with a single read and a
// single write port, and the sequencer walks it one slot per cycle. An
// allocate makes two passes (key search, then rank update). A touch, or a
// release that drops a count to zero, reads the slot and then makes one rank
// pass. Other releases and queries of a cache slot read the slot and end
// without a pass; a static or out-of-range index gives its result in the
// next cycle. The result is shown on result_o for one cycle with done_o high
// and cannot be held off. The user must write configuration through cfg_we_i
// only while idle; the block itself does not enforce this.
module refcounted_lru_slot_cache
  import rlsc_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  in_item_t        req_i,
  output logic            done_o,
  output out_item_t       result_o,
  input  logic            cfg_we_i,
  input  logic [SC_W-1:0] cfg_wdata_i
);

  localparam int unsigned LOG = $clog2(SLOTS);
  localparam logic [LOG-1:0] LAST = LOG'(SLOTS - 1);
  localparam logic [LOG:0]   SLOTS_P = (LOG + 1)'(SLOTS);
  localparam logic [LOG:0]   LAST_P = (LOG + 1)'(SLOTS - 1);

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] refs;
    logic [LOG-1:0]   rank;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  state_e           state_q, state_d;
  logic [LOG:0]     ptr_q, ptr_d;
  logic             rv_q, rv_d;
  logic [LOG-1:0]   ra_q, ra_d;
  kind_e            kind_q, kind_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [LOG-1:0]   slot_q, slot_d;
  logic [LOG-1:0]   p_q, p_d;
  mode_e            mode_q, mode_d;
  rec_t             new_rec_q, new_rec_d;
  logic             found_q, found_d;
  logic [LOG-1:0]   hit_slot_q, hit_slot_d;
  rec_t             hit_rec_q, hit_rec_d;
  logic [LOG-1:0]   lru_slot_q, lru_slot_d;
  rec_t             lru_rec_q, lru_rec_d;
  logic [SC_W-1:0]  sc_q;
  out_item_t        result_q, result_d;
  logic             done_q, done_d;

  logic             mem_we;
  logic [LOG-1:0]   mem_waddr;
  rec_t             mem_wdata;
  logic             mem_re;
  logic [LOG-1:0]   mem_raddr;
  logic [REC_W-1:0] mem_rdata;
  rec_t             rd_rec;

  logic             accept;
  logic [IDX_W:0]   idx_ext;
  logic [IDX_W:0]   sc_ext;
  logic [IDX_W:0]   cache_lim;
  logic             is_static;
  logic             is_cache;
  logic [IDX_W-1:0] idx_diff;
  logic [LOG-1:0]   acc_slot;
  logic             sweep_last;

  assign rd_rec     = rec_t'(mem_rdata);
  assign accept     = start_i && (state_q == S_IDLE);
  assign busy_o     = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign result_o   = result_q;
  assign sweep_last = rv_q && (ra_q == LAST);

  // global index decode against static_count
  assign idx_ext   = {1'b0, req_i.slot_index};
  assign sc_ext    = {2'b00, sc_q};
  assign cache_lim = sc_ext + (IDX_W + 1)'(SLOTS);
  assign is_static = idx_ext < sc_ext;
  assign is_cache  = !is_static && (idx_ext < cache_lim);
  assign idx_diff  = req_i.slot_index - {1'b0, sc_q};
  assign acc_slot  = idx_diff[LOG-1:0];

  rlsc_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH (REC_W),
    .AW    (LOG)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (ptr_q == LAST_P) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req_i.kind == KIND_ALLOC) begin
            state_d = S_SEARCH;
          end else if (is_cache) begin
            state_d = S_FETCH;
          end
        end
      end
      S_SEARCH: begin
        if (sweep_last) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_UPDATE;
      end
      S_FETCH: begin
        if (kind_q == KIND_TOUCH ||
            (kind_q == KIND_RELEASE && rd_rec.refs == CNT_W'(1))) begin
          state_d = S_UPDATE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_UPDATE: begin
        if (sweep_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    rec_t nr;
    rec_t wr;

    ptr_d      = ptr_q;
    rv_d       = 1'b0;
    ra_d       = ra_q;
    kind_d     = kind_q;
    key_d      = key_q;
    slot_d     = slot_q;
    p_d        = p_q;
    mode_d     = mode_q;
    new_rec_d  = new_rec_q;
    found_d    = found_q;
    hit_slot_d = hit_slot_q;
    hit_rec_d  = hit_rec_q;
    lru_slot_d = lru_slot_q;
    lru_rec_d  = lru_rec_q;
    result_d   = result_q;
    done_d     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = ra_q;
    mem_wdata  = rd_rec;
    mem_re     = 1'b0;
    mem_raddr  = ptr_q[LOG-1:0];
    nr         = rd_rec;
    wr         = rd_rec;

    // one slot read per cycle during the passes
    if ((state_q == S_SEARCH || state_q == S_UPDATE) && ptr_q < SLOTS_P) begin
      mem_re    = 1'b1;
      mem_raddr = ptr_q[LOG-1:0];
      ptr_d     = ptr_q + (LOG + 1)'(1);
      rv_d      = 1'b1;
      ra_d      = ptr_q[LOG-1:0];
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we          = 1'b1;
        mem_waddr       = ptr_q[LOG-1:0];
        mem_wdata.valid = 1'b0;
        mem_wdata.key   = '0;
        mem_wdata.refs  = '0;
        mem_wdata.rank  = ptr_q[LOG-1:0];
        ptr_d           = ptr_q + (LOG + 1)'(1);
      end
      S_IDLE: begin
        ptr_d = '0;
        if (accept) begin
          kind_d                = req_i.kind;
          key_d                 = req_i.key;
          slot_d                = acc_slot;
          found_d               = 1'b0;
          result_d.slot_out     = req_i.slot_index;
          result_d.hit          = 1'b0;
          result_d.evicted_busy = 1'b0;
          result_d.index_ok     = 1'b0;
          result_d.use_count    = '0;
          result_d.key_out      = '0;
          if (req_i.kind != KIND_ALLOC) begin
            if (is_cache) begin
              mem_re    = 1'b1;
              mem_raddr = acc_slot;
            end else begin
              result_d.index_ok  = is_static;
              result_d.use_count = is_static ? CNT_W'(1) : '0;
              done_d             = 1'b1;
            end
          end
        end
      end
      S_SEARCH: begin
        if (rv_q) begin
          // first valid match wins
          if (!found_q && rd_rec.valid && rd_rec.key == key_q) begin
            found_d    = 1'b1;
            hit_slot_d = ra_q;
            hit_rec_d  = rd_rec;
          end
          if (rd_rec.rank == LAST) begin
            lru_slot_d = ra_q;
            lru_rec_d  = rd_rec;
          end
        end
      end
      S_DECIDE: begin
        ptr_d  = '0;
        mode_d = MODE_FRONT;
        if (found_q) begin
          slot_d = hit_slot_q;
          p_d    = hit_rec_q.rank;
          nr     = hit_rec_q;
          if (hit_rec_q.refs != '1) begin
            nr.refs = hit_rec_q.refs + CNT_W'(1);
          end
          result_d.evicted_busy = 1'b0;
        end else begin
          slot_d   = lru_slot_q;
          p_d      = lru_rec_q.rank;
          nr.valid = 1'b1;
          nr.key   = key_q;
          nr.refs  = CNT_W'(1);
          result_d.evicted_busy = (lru_rec_q.refs != '0);
        end
        nr.rank            = '0;
        new_rec_d          = nr;
        result_d.slot_out  = {1'b0, sc_q} +
                             IDX_W'(found_q ? hit_slot_q : lru_slot_q);
        result_d.hit       = found_q;
        result_d.index_ok  = 1'b1;
        result_d.use_count = nr.refs;
        result_d.key_out   = nr.key;
      end
      S_FETCH: begin
        ptr_d = '0;
        p_d   = rd_rec.rank;
        unique case (kind_q)
          KIND_RELEASE: begin
            if (rd_rec.refs != '0) begin
              nr.refs = rd_rec.refs - CNT_W'(1);
              if (rd_rec.refs == CNT_W'(1)) begin
                // count hits zero: drop the key and send the slot to the back
                nr.valid = 1'b0;
                nr.rank  = LAST;
                mode_d   = MODE_BACK;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = slot_q;
                mem_wdata = nr;
                done_d    = 1'b1;
              end
            end else begin
              done_d = 1'b1;
            end
          end
          KIND_TOUCH: begin
            nr.rank = '0;
            mode_d  = MODE_FRONT;
          end
          KIND_QUERY: begin
            done_d = 1'b1;
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
        new_rec_d          = nr;
        result_d.index_ok  = 1'b1;
        result_d.use_count = nr.refs;
        result_d.key_out   = nr.key;
      end
      S_UPDATE: begin
        if (rv_q) begin
          if (ra_q == slot_q) begin
            wr = new_rec_q;
          end else if (mode_q == MODE_FRONT && rd_rec.rank < p_q) begin
            wr.rank = rd_rec.rank + LOG'(1);
          end else if (mode_q == MODE_BACK && rd_rec.rank > p_q) begin
            wr.rank = rd_rec.rank - LOG'(1);
          end
          mem_we    = 1'b1;
          mem_waddr = ra_q;
          mem_wdata = wr;
          done_d    = (ra_q == LAST);
        end
      end
      default: begin
        ptr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
      sc_q    <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        sc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q       <= ra_d;
    kind_q     <= kind_d;
    key_q      <= key_d;
    slot_q     <= slot_d;
    p_q        <= p_d;
    mode_q     <= mode_d;
    new_rec_q  <= new_rec_d;
    found_q    <= found_d;
    hit_slot_q <= hit_slot_d;
    hit_rec_q  <= hit_rec_d;
    lru_slot_q <= lru_slot_d;
    lru_rec_q  <= lru_rec_d;
    result_q   <= result_d;
  end

`ifndef SYNTHESIS
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !done_o)
    else $error("result during clearing pass");

  a_hit_not_evicting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.hit && result_o.evicted_busy))
    else $error("hit reported together with eviction");

  a_evict_count_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.evicted_busy) |-> (result_o.use_count == CNT_W'(1)))
    else $error("evicting miss does not report count one");

  a_read_only_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (state_q == S_SEARCH || state_q == S_UPDATE))
    else $error("pass read data outside a pass");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == S_UPDATE && done_o) |-> !busy_o)
    else $error("still busy after update pass result");
`endif

endmodule
